// File: sv/skyatl_pkg.sv
package skyatl_pkg;

	// Page geometry and limits.
	localparam int MAX_SIZE  = 1024;
	localparam int MAX_PAGES = 64;

	// Field widths.
	localparam int ADDR_W = $clog2(MAX_SIZE);
	localparam int IDX_W  = ADDR_W + 1;
	localparam int HGT_W  = 11;
	localparam int DIM_W  = 11;
	localparam int POS_W  = 10;
	localparam int PAGE_W = 7;
	localparam int STAT_W = 2;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_PLACED   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NEW_PAGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_ROOM  = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] block_width;
		logic [DIM_W-1:0] block_height;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]  x_pos;
		logic [POS_W-1:0]  y_pos;
		logic [PAGE_W-1:0] page;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

// File: sv/skyatl_colmem.sv
module skyatl_colmem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [skyatl_pkg::ADDR_W-1:0] waddr,
	input  logic [skyatl_pkg::HGT_W-1:0]  wdata,
	input  logic [skyatl_pkg::ADDR_W-1:0] raddr,
	output logic [skyatl_pkg::HGT_W-1:0]  rdata
);
	import skyatl_pkg::*;

	// Column height store: one write port and one registered read port.
	logic [HGT_W-1:0] mem_q [MAX_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/skyline_atlas_allocator_top.sv
// Skyline atlas allocator. After reset the block sweeps all 1024 column
// heights to zero, holding busy high during the sweep. A request transfer
// (start high while busy is low) then takes a data-dependent time, set
// mostly by the single read port of the column memory. Each column read
// passes an address state and a compare state, and each window start a
// check state. A failing column lets the scan skip every window that holds
// it, and an accepted window restarts the scan just right of its highest
// column, so columns that block early shorten the scan. A setup state and
// a decision state frame each scan, and placing the rectangle writes the
// new top into every column it covers. A failed attempt that opens a new
// page adds a clear of every column of the page and a second scan. The
// result appears for exactly one cycle with done high and cannot be held
// off by the receiver; busy falls in that same cycle. The atlas_size
// register accepts a write only while busy is low.
module skyline_atlas_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  skyatl_pkg::req_t              req,
	output logic                          done,
	output skyatl_pkg::res_t              res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [skyatl_pkg::DIM_W-1:0]  cfg_data
);
	import skyatl_pkg::*;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_INIT   = 4'd1;
	localparam logic [3:0] ST_SETUP  = 4'd2;
	localparam logic [3:0] ST_CHK    = 4'd3;
	localparam logic [3:0] ST_RD     = 4'd4;
	localparam logic [3:0] ST_CMP    = 4'd5;
	localparam logic [3:0] ST_DECIDE = 4'd6;
	localparam logic [3:0] ST_WRITE  = 4'd7;
	localparam logic [3:0] ST_CLEAR  = 4'd8;

	localparam logic [IDX_W-1:0]  SIZE_MAX = IDX_W'(MAX_SIZE);
	localparam logic [IDX_W-1:0]  LAST_COL = IDX_W'(MAX_SIZE - 1);
	localparam logic [PAGE_W-1:0] PAGE_LIM = PAGE_W'(MAX_PAGES);

	logic [3:0]        state_q;
	logic [DIM_W-1:0]  atlas_size_q;
	logic [IDX_W-1:0]  s_q;
	logic [DIM_W-1:0]  w_q;
	logic [DIM_W-1:0]  h_q;
	logic              retry_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  k_q;
	logic [IDX_W-1:0]  p_q;
	logic [IDX_W-1:0]  bx_q;
	logic [HGT_W-1:0]  best_q;
	logic [HGT_W-1:0]  top_q;
	logic [HGT_W-1:0]  fill_q;
	logic              found_q;
	logic [PAGE_W-1:0] pg_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              done_q;
	res_t              res_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [HGT_W-1:0]  mem_wdata;
	logic [HGT_W-1:0]  col;

	// Shared compare unit and window arithmetic.
	logic              col_blocks;
	logic              col_is_top;
	logic [HGT_W-1:0]  top_n;
	logic [IDX_W-1:0]  p_n;
	logic              win_end;
	logic              win_fits;
	logic [IDX_W:0]    stack_sum;
	logic              place_fits;
	logic [IDX_W-1:0]  eff_size;

	assign col_blocks = (col >= best_q);
	assign col_is_top = (col >= top_q);
	assign top_n      = col_is_top ? col : top_q;
	assign p_n        = col_is_top ? k_q : p_q;
	assign win_end    = ({1'b0, k_q} + (IDX_W+1)'(1)) == ({1'b0, i_q} + {1'b0, w_q});
	assign win_fits   = ({1'b0, i_q} + {1'b0, w_q}) < {1'b0, s_q};
	assign stack_sum  = {1'b0, best_q} + {1'b0, h_q};
	assign place_fits = found_q && (stack_sum <= {1'b0, s_q});
	assign eff_size   = (atlas_size_q > SIZE_MAX) ? SIZE_MAX : atlas_size_q;

	// Column memory write port: sweeps write zero, placement writes the new top.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[ADDR_W-1:0];
		mem_wdata = '0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(bx_q + cnt_q);
				mem_wdata = fill_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	skyatl_colmem u_colmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (k_q[ADDR_W-1:0]),
		.rdata (col)
	);

	// Configuration register transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_size_q <= DIM_W'(MAX_SIZE);
		end else if (cfg_valid && cfg_ready) begin
			atlas_size_q <= cfg_data;
		end
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			pg_q    <= '0;
			done_q  <= 1'b0;
			retry_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == LAST_COL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						w_q     <= req.block_width;
						h_q     <= req.block_height;
						s_q     <= eff_size;
						retry_q <= 1'b0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					best_q  <= s_q[HGT_W-1:0];
					top_q   <= '0;
					i_q     <= '0;
					k_q     <= '0;
					found_q <= 1'b0;
					state_q <= ST_CHK;
					// A zero-wide request fits at the last scanned start column.
					if (w_q == '0) begin
						state_q <= ST_DECIDE;
						if (s_q != '0) begin
							found_q <= 1'b1;
							bx_q    <= s_q - IDX_W'(1);
							best_q  <= '0;
						end
					end
				end
				ST_CHK: begin
					state_q <= win_fits ? ST_RD : ST_DECIDE;
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (col_blocks) begin
						// Every window holding this column fails as well.
						i_q     <= k_q + IDX_W'(1);
						k_q     <= k_q + IDX_W'(1);
						top_q   <= '0;
						state_q <= ST_CHK;
					end else if (win_end) begin
						// Window accepted; windows holding its highest column now fail.
						found_q <= 1'b1;
						bx_q    <= i_q;
						best_q  <= top_n;
						i_q     <= p_n + IDX_W'(1);
						k_q     <= p_n + IDX_W'(1);
						top_q   <= '0;
						state_q <= ST_CHK;
					end else begin
						top_q   <= top_n;
						p_q     <= p_n;
						k_q     <= k_q + IDX_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (place_fits) begin
						fill_q       <= stack_sum[HGT_W-1:0];
						res_q.x_pos  <= bx_q[POS_W-1:0];
						res_q.y_pos  <= best_q[POS_W-1:0];
						res_q.page   <= pg_q;
						res_q.status <= retry_q ? STAT_NEW_PAGE : STAT_PLACED;
						if (w_q == '0) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_WRITE;
						end
					end else if (retry_q || (pg_q >= PAGE_LIM)) begin
						// An unchanged page would fail the retry the same way.
						res_q.x_pos  <= '0;
						res_q.y_pos  <= '0;
						res_q.page   <= pg_q;
						res_q.status <= STAT_NO_ROOM;
						done_q       <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						pg_q    <= pg_q + PAGE_W'(1);
						retry_q <= 1'b1;
						res_q.page <= pg_q + PAGE_W'(1);
						state_q <= (s_q == '0) ? ST_SETUP : ST_CLEAR;
					end
				end
				ST_WRITE: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if ((cnt_q + IDX_W'(1)) == w_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if ((cnt_q + IDX_W'(1)) == s_q) begin
						state_q <= ST_SETUP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign res       = res_q;
	assign cfg_ready = !busy;

endmodule

// File: tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import skyatl_pkg::*;

	// One directed request; the expected placement is only used when pinned is set.
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic             pinned;
		res_t             want;
	} rect_row_t;

	// One random phase: the atlas side in use and the spread of the requests.
	typedef struct packed {
		int side;
		int count;
		int wmax;
		int hmax;
	} size_phase_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	res_t             res;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [DIM_W-1:0] cfg_data;

	// Shadow of the allocator: skyline, page counter and the side register.
	int               sky_heights [MAX_SIZE];
	logic [DIM_W-1:0] side_reg;
	int               page_ctr;

	res_t placements_due [$];

	int  mismatches;
	int  cycles;
	int  cycle_limit;
	int  n_requests;
	int  n_placed;
	int  n_fresh;
	int  n_refused;
	int  n_sides;
	int  top_page;
	bit  no_idle;

	// Fresh page, extremes of both fields, the exclusive scan bound, zero sizes,
	// a window blocked by a full column, and a fill that forces a new page.
	rect_row_t rect_rows [19] = '{
		'{11'd1,    11'd1,    1'b1, '{10'd0,    10'd0, 7'd0, STAT_PLACED}},
		'{11'd1023, 11'd1,    1'b0, '0},
		'{11'd1024, 11'd1,    1'b1, '{10'd0,    10'd0, 7'd1, STAT_NO_ROOM}},
		'{11'd2047, 11'd2047, 1'b1, '{10'd0,    10'd0, 7'd2, STAT_NO_ROOM}},
		'{11'd1,    11'd1024, 1'b1, '{10'd0,    10'd0, 7'd2, STAT_PLACED}},
		'{11'd1,    11'd2047, 1'b1, '{10'd0,    10'd0, 7'd3, STAT_NO_ROOM}},
		'{11'd0,    11'd0,    1'b1, '{10'd1023, 10'd0, 7'd3, STAT_PLACED}},
		'{11'd0,    11'd2047, 1'b1, '{10'd0,    10'd0, 7'd4, STAT_NO_ROOM}},
		'{11'd1,    11'd0,    1'b1, '{10'd0,    10'd0, 7'd4, STAT_PLACED}},
		'{11'd512,  11'd512,  1'b0, '0},
		'{11'd512,  11'd512,  1'b0, '0},
		'{11'd512,  11'd1,    1'b0, '0},
		'{11'h555,  11'h2AA,  1'b0, '0},
		'{11'h2AA,  11'h555,  1'b0, '0},
		'{11'd3,    11'd5,    1'b0, '0},
		'{11'd1,    11'd1,    1'b0, '0},
		'{11'd1022, 11'd1000, 1'b0, '0},
		'{11'd1,    11'd1023, 1'b0, '0},
		'{11'd2,    11'd2,    1'b0, '0}
	};

	// Large sides first with narrow requests, then small sides that fill pages
	// quickly until the page limit is hit.
	size_phase_t size_phases [10] = '{
		'{2047, 12, 4,  1100},
		'{1024, 12, 4,  300},
		'{64,   45, 66, 66},
		'{0,    4,  3,  3},
		'{16,   40, 18, 18},
		'{1,    4,  2,  2},
		'{37,   35, 39, 39},
		'{8,    35, 10, 10},
		'{2,    60, 3,  3},
		'{5,    20, 7,  7}
	};

	skyline_atlas_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Side of the page actually in use: the register saturates at MAX_SIZE.
	function automatic int page_side();
		return (side_reg > MAX_SIZE) ? MAX_SIZE : int'(side_reg);
	endfunction

	// Worst-case cycles for one request: two scans, two fills and a page clear.
	function automatic int request_budget(input int w);
		int s;
		int wc;
		s = page_side();
		wc = (w < s) ? w : s;
		return 4 * (2 * (2 * s * (wc + 1) + wc + 8) + s) + 200;
	endfunction

	// Scan the skyline for the lowest window and raise it; returns 0 if no fit.
	function automatic bit fit_rect(input int w, input int h, output int x, output int y);
		int s;
		int best;
		int bx;
		int top;
		int i;
		int j;
		bit found;
		bit ok;
		s = page_side();
		best = s;
		bx = 0;
		found = 1'b0;
		if (w < s) begin
			for (i = 0; i < s - w; i++) begin
				top = 0;
				ok = 1'b1;
				for (j = 0; j < w; j++) begin
					if (sky_heights[i + j] >= best) begin
						ok = 1'b0;
						break;
					end
					if (sky_heights[i + j] > top)
						top = sky_heights[i + j];
				end
				if (ok) begin
					bx = i;
					best = top;
					found = 1'b1;
				end
			end
		end
		if (!found || best + h > s)
			return 1'b0;
		for (i = 0; i < w; i++)
			sky_heights[bx + i] = (best + h) & 'h7FF;
		x = bx;
		y = best;
		return 1'b1;
	endfunction

	// Open the next page unless the limit is reached; only the live side is cleared.
	function automatic void open_page();
		int i;
		if (page_ctr >= MAX_PAGES)
			return;
		page_ctr++;
		for (i = 0; i < page_side(); i++)
			sky_heights[i] = 0;
	endfunction

	// Placement for one request, with a single retry on a fresh page.
	function automatic res_t place_rect(input int w, input int h);
		res_t r;
		int x;
		int y;
		x = 0;
		y = 0;
		if (fit_rect(w, h, x, y)) begin
			r.status = STAT_PLACED;
		end else begin
			open_page();
			if (fit_rect(w, h, x, y)) begin
				r.status = STAT_NEW_PAGE;
			end else begin
				x = 0;
				y = 0;
				r.status = STAT_NO_ROOM;
			end
		end
		r.x_pos = x[POS_W-1:0];
		r.y_pos = y[POS_W-1:0];
		r.page = page_ctr[PAGE_W-1:0];
		return r;
	endfunction

	// Offer one request, possibly after an idle gap, and log its placement on transfer.
	task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic pinned, input res_t want);
		int gap;
		res_t predicted;
		gap = 0;
		if (!no_idle && $urandom_range(99) < 34)
			gap = ($urandom_range(3) == 0) ? $urandom_range(600, 1) : $urandom_range(4, 1);
		cycle_limit += request_budget(int'(w)) + gap;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= '{block_width: w, block_height: h};
		@(posedge clk);
		while (busy) @(posedge clk);
		predicted = place_rect(int'(w), int'(h));
		placements_due.push_back(pinned ? want : predicted);
		n_requests++;
		@(negedge clk);
	endtask

	// Let the block go idle: no request offered and every placement back.
	task automatic drain_rects();
		start <= 1'b0;
		while (placements_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write the atlas side register through its own channel.
	task automatic write_side(input logic [DIM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		side_reg = value;
		n_sides++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Watchdog on the total cycle budget.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > cycle_limit) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, placements_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Compare every result strobe with the oldest outstanding placement.
	always @(posedge clk) begin
		res_t exp_res;
		if (arst_n && done === 1'b1) begin
			if (placements_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: x=%0d y=%0d page=%0d status=%0d",
						res.x_pos, res.y_pos, res.page, res.status);
			end else begin
				exp_res = placements_due.pop_front();
				if (res.x_pos !== exp_res.x_pos || res.y_pos !== exp_res.y_pos ||
						res.page !== exp_res.page || res.status !== exp_res.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"Mismatch: expected x=%0d y=%0d page=%0d status=%0d, ",
							"got x=%0d y=%0d page=%0d status=%0d"},
							exp_res.x_pos, exp_res.y_pos, exp_res.page, exp_res.status,
							res.x_pos, res.y_pos, res.page, res.status);
				end
			end
			case (res.status)
				STAT_PLACED:   n_placed++;
				STAT_NEW_PAGE: n_fresh++;
				default:       n_refused++;
			endcase
			if (int'(res.page) > top_page)
				top_page = int'(res.page);
		end
	end

	// Stimulus: reset, the directed table, then one random phase per atlas side.
	initial begin
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		int i;
		int k;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		side_reg = 11'd1024;
		page_ctr = 0;
		for (i = 0; i < MAX_SIZE; i++)
			sky_heights[i] = 0;
		mismatches = 0;
		cycles = 0;
		cycle_limit = 8 * MAX_SIZE + 2000;
		n_requests = 0;
		n_placed = 0;
		n_fresh = 0;
		n_refused = 0;
		n_sides = 0;
		top_page = 0;
		no_idle = 1'b0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < $size(rect_rows); i++)
			send_rect(rect_rows[i].w, rect_rows[i].h, rect_rows[i].pinned, rect_rows[i].want);

		for (i = 0; i < $size(size_phases); i++) begin
			drain_rects();
			write_side(size_phases[i].side[DIM_W-1:0]);
			for (k = 0; k < size_phases[i].count; k++) begin
				// A window of back-to-back requests with no idling at all.
				no_idle = (n_requests >= 140 && n_requests < 190);
				if (page_side() <= 64 && $urandom_range(9) == 0) begin
					w = DIM_W'($urandom_range(2047, 0));
					h = DIM_W'($urandom_range(2047, 0));
				end else begin
					w = DIM_W'($urandom_range(size_phases[i].wmax, 0));
					h = DIM_W'($urandom_range(size_phases[i].hmax, 0));
				end
				send_rect(w, h, 1'b0, '0);
			end
		end

		drain_rects();
		cycle_limit += 2000;
		repeat (50) @(posedge clk);

		$display({"Covered %0d requests over %0d side settings: ",
			"%0d placed, %0d on a new page, %0d refused."},
			n_requests, n_sides + 1, n_placed, n_fresh, n_refused);
		$display("Highest page reached: %0d of %0d; %0d mismatches.",
			top_page, MAX_PAGES, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
